// ===== rtl/eop_pkg.sv =====
package eop_pkg;

  // Field widths fixed by the register map
  localparam int COEF_W    = 32;
  localparam int RAD_W     = 28;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Square of a radius product and its scaled copies
  localparam int RR_W  = 2 * RAD_W;
  localparam int RSQ_W = 2 * RR_W;
  localparam int RSC_W = RSQ_W + 4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [RAD_W-1:0]         rad_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_M00 = 3'd0;
  localparam cfg_idx_t REG_M01 = 3'd1;
  localparam cfg_idx_t REG_M02 = 3'd2;
  localparam cfg_idx_t REG_M10 = 3'd3;
  localparam cfg_idx_t REG_M11 = 3'd4;
  localparam cfg_idx_t REG_M12 = 3'd5;
  localparam cfg_idx_t REG_RX  = 3'd6;
  localparam cfg_idx_t REG_RY  = 3'd7;

  // Reset values: unit scale in fixed point
  localparam coef_t COEF_ONE = COEF_W'(1) << FRAC_BITS;
  localparam coef_t COEF_ZERO = '0;
  localparam rad_t  RAD_ONE  = RAD_W'(1) << FRAC_BITS;

endpackage

// ===== rtl/eop_affine.sv =====
module eop_affine #(
  parameter int COORD_W = 12
) (
  input  logic                                  clk,
  input  logic                                  adv,
  input  logic signed [COORD_W-1:0]             pixel_x,
  input  logic signed [COORD_W-1:0]             pixel_y,
  input  eop_pkg::coef_t                        m00,
  input  eop_pkg::coef_t                        m01,
  input  eop_pkg::coef_t                        m02,
  input  eop_pkg::coef_t                        m10,
  input  eop_pkg::coef_t                        m11,
  input  eop_pkg::coef_t                        m12,
  output logic [eop_pkg::COEF_W+COORD_W+1:0]    mag_x,
  output logic [eop_pkg::COEF_W+COORD_W+1:0]    mag_y
);

  localparam int PW = eop_pkg::COEF_W + COORD_W;
  localparam int LW = PW + 2;

  logic signed [PW-1:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [LW-1:0] lx_r, ly_r;
  logic [LW-1:0]        mag_x_r, mag_y_r;

  // Stage 1: coefficient by coordinate products
  // Stage 2: sum with translation into the local frame
  // Stage 3: take magnitudes, the sign drops out when squared
  always_ff @(posedge clk) begin
    if (adv) begin
      p00_r   <= PW'(m00) * PW'(pixel_x);
      p01_r   <= PW'(m01) * PW'(pixel_y);
      p10_r   <= PW'(m10) * PW'(pixel_x);
      p11_r   <= PW'(m11) * PW'(pixel_y);
      lx_r    <= LW'(p00_r) + LW'(p01_r) + LW'(m02);
      ly_r    <= LW'(p10_r) + LW'(p11_r) + LW'(m12);
      mag_x_r <= lx_r[LW-1] ? $unsigned(-lx_r) : $unsigned(lx_r);
      mag_y_r <= ly_r[LW-1] ? $unsigned(-ly_r) : $unsigned(ly_r);
    end
  end

  assign mag_x = mag_x_r;
  assign mag_y = mag_y_r;

endmodule

// ===== rtl/eop_square.sv =====
module eop_square #(
  parameter int IN_W = 46
) (
  input  logic                                   clk,
  input  logic                                   adv,
  input  logic [IN_W-1:0]                        mag,
  input  eop_pkg::rad_t                          rad,
  output logic [2*(IN_W+eop_pkg::RAD_W)-1:0]     sq
);

  localparam int PP    = IN_W + eop_pkg::RAD_W;
  localparam int SQ_W  = 2 * PP;
  localparam int LO_W  = IN_W / 2;
  localparam int HI_W  = IN_W - LO_W;
  localparam int PLO_W = LO_W + eop_pkg::RAD_W;
  localparam int PHI_W = HI_W + eop_pkg::RAD_W;
  localparam int L     = (PP + 2) / 3;
  localparam int QW    = 2 * L;

  logic [PLO_W-1:0] plo_r;
  logic [PHI_W-1:0] phi_r;
  logic [PP-1:0]    p_r;
  logic [L-1:0]     a0, a1, a2;
  logic [QW-1:0]    q00_r, q01_r, q02_r, q11_r, q12_r, q22_r;
  logic [SQ_W-1:0]  u_r, v_r, sq_r;

  // Split the product into three limbs for squaring
  assign a0 = p_r[L-1:0];
  assign a1 = p_r[2*L-1:L];
  assign a2 = L'(p_r[PP-1:2*L]);

  // Stage 4: magnitude by radius in two halves
  // Stage 5: join the halves
  // Stage 6: limb products of the square
  // Stage 7: gather low and high partial sums
  // Stage 8: final square
  always_ff @(posedge clk) begin
    if (adv) begin
      plo_r <= PLO_W'(mag[LO_W-1:0]) * PLO_W'(rad);
      phi_r <= PHI_W'(mag[IN_W-1:LO_W]) * PHI_W'(rad);
      p_r   <= PP'(plo_r) + (PP'(phi_r) << LO_W);
      q00_r <= QW'(a0) * QW'(a0);
      q01_r <= QW'(a0) * QW'(a1);
      q02_r <= QW'(a0) * QW'(a2);
      q11_r <= QW'(a1) * QW'(a1);
      q12_r <= QW'(a1) * QW'(a2);
      q22_r <= QW'(a2) * QW'(a2);
      u_r   <= SQ_W'(q00_r) + (SQ_W'(q01_r) << (L + 1)) + (SQ_W'(q11_r) << (2 * L));
      v_r   <= (SQ_W'(q02_r) << (2 * L + 1)) + (SQ_W'(q12_r) << (3 * L + 1))
               + (SQ_W'(q22_r) << (4 * L));
      sq_r  <= u_r + v_r;
    end
  end

  assign sq = sq_r;

endmodule

// ===== rtl/eop_radius.sv =====
module eop_radius (
  input  logic                            clk,
  input  eop_pkg::rad_t                   radius_x,
  input  eop_pkg::rad_t                   radius_y,
  output logic [eop_pkg::RSC_W-1:0]       r9,
  output logic [eop_pkg::RSC_W-1:0]       r11
);

  localparam int RW  = eop_pkg::RAD_W;
  localparam int RRW = eop_pkg::RR_W;
  localparam int RSW = eop_pkg::RSQ_W;
  localparam int SCW = eop_pkg::RSC_W;

  logic [RRW-1:0] rr_r;
  logic [RRW-1:0] h00_r, h01_r, h11_r;
  logic [RSW-1:0] r_r;
  logic [SCW-1:0] r9_r, r11_r;

  // Free-running: settles after a register write, well ahead of
  // any pixel that follows the write
  always_ff @(posedge clk) begin
    rr_r  <= RRW'(radius_x) * RRW'(radius_y);
    h00_r <= RRW'(rr_r[RW-1:0]) * RRW'(rr_r[RW-1:0]);
    h01_r <= RRW'(rr_r[RW-1:0]) * RRW'(rr_r[RRW-1:RW]);
    h11_r <= RRW'(rr_r[RRW-1:RW]) * RRW'(rr_r[RRW-1:RW]);
    r_r   <= RSW'(h00_r) + (RSW'(h01_r) << (RW + 1)) + (RSW'(h11_r) << RRW);
    r9_r  <= (SCW'(r_r) << 3) + SCW'(r_r);
    r11_r <= (SCW'(r_r) << 3) + (SCW'(r_r) << 1) + SCW'(r_r);
  end

  assign r9  = r9_r;
  assign r11 = r11_r;

endmodule

// ===== rtl/ellipse_outline_pixel_test.sv =====
// Ellipse outline pixel test. Each word on the in_ channel carries one screen
// pixel; it is mapped through the inverse affine transform held in registers
// 0..5 (signed Q16.16) and tested against the ellipse of radii radius_x and
// radius_y (registers 6 and 7, unsigned Q12.16). out_on_outline is 1 when
// |lx^2/rx^2 + ly^2/ry^2 - 1| < 0.1, decided exactly without division; the
// pixel coordinates come back alongside. The block takes one pixel every
// cycle while no finished word is held at out_, in an eleven-stage pipeline
// set by the chain of multiplies (transform, radius scaling, limb squaring)
// and the wide sums and compares behind them. A stall on out_ holds every
// stage while a finished word waits. Write registers only when no pixel is
// in flight; the radius product settles before any new pixel needs it.
module ellipse_outline_pixel_test #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_BITS-1:0]           in_pixel_x,
  input  logic signed [COORD_BITS-1:0]           in_pixel_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [COORD_BITS-1:0]           out_x,
  output logic signed [COORD_BITS-1:0]           out_y,
  output logic                                   out_on_outline,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  eop_pkg::cfg_idx_t                      cfg_index,
  input  logic [eop_pkg::CFG_DAT_W-1:0]          cfg_data
);

  localparam int NSTG  = 11;
  localparam int MAG_W = eop_pkg::COEF_W + COORD_BITS + 2;
  localparam int SQ_W  = 2 * (MAG_W + eop_pkg::RAD_W);
  localparam int SUM_W = SQ_W + 1;
  localparam int S10_W = SQ_W + 5;

  eop_pkg::coef_t m00_r, m01_r, m02_r, m10_r, m11_r, m12_r;
  eop_pkg::rad_t  rx_r, ry_r;

  logic                         adv;
  logic [NSTG-1:0]              vld_r;
  logic signed [COORD_BITS-1:0] x_r [NSTG];
  logic signed [COORD_BITS-1:0] y_r [NSTG];

  logic [MAG_W-1:0]             mag_x, mag_y;
  logic [SQ_W-1:0]              sq_x, sq_y;
  logic [eop_pkg::RSC_W-1:0]    r9, r11;
  logic [SUM_W-1:0]             s_r;
  logic [S10_W-1:0]             s10_r;
  logic                         hit_r;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m00_r <= eop_pkg::COEF_ONE;
      m01_r <= eop_pkg::COEF_ZERO;
      m02_r <= eop_pkg::COEF_ZERO;
      m10_r <= eop_pkg::COEF_ZERO;
      m11_r <= eop_pkg::COEF_ONE;
      m12_r <= eop_pkg::COEF_ZERO;
      rx_r  <= eop_pkg::RAD_ONE;
      ry_r  <= eop_pkg::RAD_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        eop_pkg::REG_M00: m00_r <= eop_pkg::coef_t'(cfg_data);
        eop_pkg::REG_M01: m01_r <= eop_pkg::coef_t'(cfg_data);
        eop_pkg::REG_M02: m02_r <= eop_pkg::coef_t'(cfg_data);
        eop_pkg::REG_M10: m10_r <= eop_pkg::coef_t'(cfg_data);
        eop_pkg::REG_M11: m11_r <= eop_pkg::coef_t'(cfg_data);
        eop_pkg::REG_M12: m12_r <= eop_pkg::coef_t'(cfg_data);
        eop_pkg::REG_RX:  rx_r  <= cfg_data[eop_pkg::RAD_W-1:0];
        eop_pkg::REG_RY:  ry_r  <= cfg_data[eop_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a finished word is held at the output
  assign adv      = !(vld_r[NSTG-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Carry the coordinates alongside the arithmetic
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= in_pixel_x;
      y_r[0] <= in_pixel_y;
      for (int k = 1; k < NSTG; k++) begin
        x_r[k] <= x_r[k-1];
        y_r[k] <= y_r[k-1];
      end
    end
  end

  eop_affine #(
    .COORD_W (COORD_BITS)
  ) u_affine (
    .clk     (clk),
    .adv     (adv),
    .pixel_x (in_pixel_x),
    .pixel_y (in_pixel_y),
    .m00     (m00_r),
    .m01     (m01_r),
    .m02     (m02_r),
    .m10     (m10_r),
    .m11     (m11_r),
    .m12     (m12_r),
    .mag_x   (mag_x),
    .mag_y   (mag_y)
  );

  // lx^2 * ry^2 and ly^2 * rx^2
  eop_square #(
    .IN_W (MAG_W)
  ) u_sq_x (
    .clk (clk),
    .adv (adv),
    .mag (mag_x),
    .rad (ry_r),
    .sq  (sq_x)
  );

  eop_square #(
    .IN_W (MAG_W)
  ) u_sq_y (
    .clk (clk),
    .adv (adv),
    .mag (mag_y),
    .rad (rx_r),
    .sq  (sq_y)
  );

  eop_radius u_radius (
    .clk      (clk),
    .radius_x (rx_r),
    .radius_y (ry_r),
    .r9       (r9),
    .r11      (r11)
  );

  // Stage 9: sum of terms; stage 10: scale by ten; stage 11: band compare
  always_ff @(posedge clk) begin
    if (adv) begin
      s_r   <= SUM_W'(sq_x) + SUM_W'(sq_y);
      s10_r <= (S10_W'(s_r) << 3) + (S10_W'(s_r) << 1);
      hit_r <= (S10_W'(r9) < s10_r) && (s10_r < S10_W'(r11));
    end
  end

  assign out_valid      = vld_r[NSTG-1];
  assign out_x          = x_r[NSTG-1];
  assign out_y          = y_r[NSTG-1];
  assign out_on_outline = hit_r;

endmodule

// ===== bench/testbench.sv =====
module testbench;

  localparam int  COORD_BITS   = 12;
  localparam int  PIX_MAX      = 2 ** (COORD_BITS - 1) - 1;
  localparam int  PIX_MIN      = -PIX_MAX - 1;
  localparam int  MAX_GAP      = 6;
  localparam int  PIPE_DEPTH   = 11;
  localparam int  HOLD_CYCLES  = 80;
  localparam int  IDLE_LIMIT   = 2000;
  localparam int  RANDOM_ITEMS = 600;
  localparam int  WIDE_W       = 192;
  localparam real TWO_PI       = 6.283185307179586;
  localparam real Q_ONE        = 65536.0;

  typedef logic signed [COORD_BITS-1:0] pix_t;
  typedef logic [WIDE_W-1:0]            wide_t;
  typedef logic [eop_pkg::CFG_DAT_W-1:0] cfg_dat_t;

  typedef struct {
    pix_t x;
    pix_t y;
    logic hit;
  } pixel_word_t;

  typedef enum logic { ROW_PIX, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    eop_pkg::cfg_idx_t idx;
    cfg_dat_t          data;
    pix_t              x;
    pix_t              y;
    logic              typed;
    logic              hit;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  pix_t              in_pixel_x;
  pix_t              in_pixel_y;
  logic              out_valid;
  logic              out_stall;
  pix_t              out_x;
  pix_t              out_y;
  logic              out_on_outline;
  logic              cfg_valid;
  logic              cfg_ready;
  eop_pkg::cfg_idx_t cfg_index;
  cfg_dat_t          cfg_data;

  // Local copy of the transform and radii
  eop_pkg::coef_t xform_coef [6];
  eop_pkg::rad_t  rad_x_q;
  eop_pkg::rad_t  rad_y_q;

  pixel_word_t pending_pixels [$];
  dir_row_t    directed_rows [$];

  int mismatches    = 0;
  int words_checked = 0;
  int hits_seen     = 0;
  int pixels_sent   = 0;
  int reg_writes    = 0;
  int phases_run    = 0;
  int idle_cycles   = 0;
  bit send_idle     = 1'b0;
  bit recv_idle     = 1'b0;
  bit hold_req      = 1'b0;

  ellipse_outline_pixel_test #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_on_outline(out_on_outline),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Map the pixel into the ellipse frame and test the band exactly:
  // 9*R < 10*S < 11*R with S = lx^2*ry^2 + ly^2*rx^2, R = (rx*ry)^2
  function automatic logic outline_hit(pix_t px, pix_t py);
    logic signed [63:0] sx, sy, lx, ly;
    logic [63:0]        abs_x, abs_y;
    wide_t              mx, my, rx, ry, tx, ty, rr, sum10;
    sx = 64'(px);
    sy = 64'(py);
    lx = xform_coef[eop_pkg::REG_M00] * sx + xform_coef[eop_pkg::REG_M01] * sy
         + xform_coef[eop_pkg::REG_M02];
    ly = xform_coef[eop_pkg::REG_M10] * sx + xform_coef[eop_pkg::REG_M11] * sy
         + xform_coef[eop_pkg::REG_M12];
    abs_x = (lx < 0) ? $unsigned(-lx) : $unsigned(lx);
    abs_y = (ly < 0) ? $unsigned(-ly) : $unsigned(ly);
    mx = wide_t'(abs_x);
    my = wide_t'(abs_y);
    rx = wide_t'(rad_x_q);
    ry = wide_t'(rad_y_q);
    tx = mx * ry;
    tx = tx * tx;
    ty = my * rx;
    ty = ty * ty;
    rr = rx * ry;
    rr = rr * rr;
    sum10 = (tx + ty) * 10;
    return (rr * 9 < sum10) && (sum10 < rr * 11);
  endfunction

  function automatic dir_row_t pix_row(int x, int y, logic typed, logic hit);
    dir_row_t r;
    r.kind  = ROW_PIX;
    r.idx   = eop_pkg::REG_M00;
    r.data  = '0;
    r.x     = pix_t'(x);
    r.y     = pix_t'(y);
    r.typed = typed;
    r.hit   = hit;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(eop_pkg::cfg_idx_t idx, cfg_dat_t data);
    dir_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = data;
    r.x     = '0;
    r.y     = '0;
    r.typed = 1'b0;
    r.hit   = 1'b0;
    return r;
  endfunction

  // Round a screen position to the nearest pixel, held inside the coordinate range
  function automatic pix_t to_pix(real v);
    int k;
    if (v > PIX_MAX) begin
      k = PIX_MAX;
    end else if (v < PIX_MIN) begin
      k = PIX_MIN;
    end else begin
      k = int'(v);
    end
    return pix_t'(k);
  endfunction

  function automatic int signed_scale();
    int m;
    m = $urandom_range(32768, 131072);
    if ($urandom_range(0, 1) == 1) begin
      m = -m;
    end
    return m;
  endfunction

  // Write one register and track it in the local copy; valid stays up for the caller
  task automatic write_reg(eop_pkg::cfg_idx_t idx, cfg_dat_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      eop_pkg::REG_RX: begin
        rad_x_q = data[eop_pkg::RAD_W-1:0];
      end
      eop_pkg::REG_RY: begin
        rad_y_q = data[eop_pkg::RAD_W-1:0];
      end
      default: begin
        xform_coef[idx] = data;
      end
    endcase
    reg_writes++;
  endtask

  // Drop valid and wait until every pixel in flight has come back
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Offer one pixel after a random gap when send_idle is set and log its expected word once taken
  task automatic send_pixel(pix_t px, pix_t py, logic typed, logic typed_hit);
    int          gap;
    pixel_word_t w;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    w.x   = px;
    w.y   = py;
    w.hit = typed ? typed_hit : outline_hit(px, py);
    pending_pixels.push_back(w);
    pixels_sent++;
  endtask

  // One random setting followed by a burst of pixels
  task automatic random_phase(int n_items, bit squeeze);
    bit  wild;
    int  i, k;
    int  cx, cy, m00, m01, m02, m10, m11, m12, rxv, ryv;
    real a, b, c, d, det, theta, spread, lxr, lyr;
    pix_t px, py;
    wild      = ($urandom_range(0, 3) == 0);
    send_idle = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
    drain_pipeline();
    // Sheared and scaled ellipse centred somewhere on screen, or anything at all
    cx  = $urandom_range(0, 1200) - 600;
    cy  = $urandom_range(0, 1200) - 600;
    m00 = signed_scale();
    m11 = signed_scale();
    m01 = $urandom_range(0, 32768) - 16384;
    m10 = $urandom_range(0, 32768) - 16384;
    m02 = -(m00 * cx + m01 * cy) + ($urandom_range(0, 131070) - 65535);
    m12 = -(m10 * cx + m11 * cy) + ($urandom_range(0, 131070) - 65535);
    rxv = $urandom_range(2 << eop_pkg::FRAC_BITS, 150 << eop_pkg::FRAC_BITS);
    ryv = $urandom_range(2 << eop_pkg::FRAC_BITS, 150 << eop_pkg::FRAC_BITS);
    if (wild) begin
      for (i = 0; i <= int'(eop_pkg::REG_RY); i++) begin
        write_reg(eop_pkg::cfg_idx_t'(i), $urandom());
      end
    end else begin
      write_reg(eop_pkg::REG_M00, m00);
      write_reg(eop_pkg::REG_M01, m01);
      write_reg(eop_pkg::REG_M02, m02);
      write_reg(eop_pkg::REG_M10, m10);
      write_reg(eop_pkg::REG_M11, m11);
      write_reg(eop_pkg::REG_M12, m12);
      write_reg(eop_pkg::REG_RX, rxv);
      write_reg(eop_pkg::REG_RY, ryv);
    end
    cfg_valid <= 1'b0;
    if (squeeze) begin
      hold_req = 1'b1;
    end
    a   = m00 / Q_ONE;
    b   = m01 / Q_ONE;
    c   = m10 / Q_ONE;
    d   = m11 / Q_ONE;
    det = a * d - b * c;
    repeat (n_items) begin
      if (wild || $urandom_range(0, 4) == 0) begin
        px = pix_t'($urandom());
        py = pix_t'($urandom());
      end else begin
        // Aim at the outline with a radial spread of about twelve percent
        theta  = TWO_PI * $urandom_range(0, 65535) / 65536.0;
        k      = $urandom_range(0, 2400);
        spread = 1.0 + (k - 1200) / 10000.0;
        lxr    = rxv / Q_ONE * spread * $cos(theta) - m02 / Q_ONE;
        lyr    = ryv / Q_ONE * spread * $sin(theta) - m12 / Q_ONE;
        px     = to_pix((d * lxr - b * lyr) / det);
        py     = to_pix((a * lyr - c * lxr) / det);
      end
      send_pixel(px, py, 1'b0, 1'b0);
    end
  endtask

  // Result side: random stall per word, plus one long hold on request
  initial begin : receiver
    int gap;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : word_check
    pixel_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: x=%0d y=%0d on_outline=%0b",
                   out_x, out_y, out_on_outline);
        end
      end else begin
        want = pending_pixels.pop_front();
        words_checked++;
        if (out_on_outline === 1'b1) begin
          hits_seen++;
        end
        if (out_x !== want.x || out_y !== want.y || out_on_outline !== want.hit) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected x=%0d y=%0d on_outline=%0b",
                     want.x, want.y, want.hit);
            $display("          got      x=%0d y=%0d on_outline=%0b",
                     out_x, out_y, out_on_outline);
          end
        end
      end
    end
  end

  // End the run if no handshake happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    bit       cfg_open;
    int       sent_random, n;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= eop_pkg::REG_M00;
    cfg_data   <= '0;
    xform_coef[eop_pkg::REG_M00] = eop_pkg::COEF_ONE;
    xform_coef[eop_pkg::REG_M01] = eop_pkg::COEF_ZERO;
    xform_coef[eop_pkg::REG_M02] = eop_pkg::COEF_ZERO;
    xform_coef[eop_pkg::REG_M10] = eop_pkg::COEF_ZERO;
    xform_coef[eop_pkg::REG_M11] = eop_pkg::COEF_ONE;
    xform_coef[eop_pkg::REG_M12] = eop_pkg::COEF_ZERO;
    rad_x_q = eop_pkg::RAD_ONE;
    rad_y_q = eop_pkg::RAD_ONE;

    // Unit circle after reset: axis points sit on the outline, the rest do not
    directed_rows.push_back(pix_row(0, 0, 1'b1, 1'b0));
    directed_rows.push_back(pix_row(1, 0, 1'b1, 1'b1));
    directed_rows.push_back(pix_row(-1, 0, 1'b1, 1'b1));
    directed_rows.push_back(pix_row(0, 1, 1'b1, 1'b1));
    directed_rows.push_back(pix_row(0, -1, 1'b1, 1'b1));
    directed_rows.push_back(pix_row(1, 1, 1'b1, 1'b0));
    directed_rows.push_back(pix_row(PIX_MAX, PIX_MAX, 1'b1, 1'b0));
    directed_rows.push_back(pix_row(PIX_MIN, PIX_MIN, 1'b1, 1'b0));
    directed_rows.push_back(pix_row(PIX_MIN, PIX_MAX, 1'b1, 1'b0));
    directed_rows.push_back(pix_row(PIX_MAX, PIX_MIN, 1'b1, 1'b0));
    // Only bits above the radius width set: radius becomes zero, nothing hits
    directed_rows.push_back(cfg_row(eop_pkg::REG_RX, 32'hF000_0000));
    directed_rows.push_back(pix_row(1, 0, 1'b1, 1'b0));
    directed_rows.push_back(pix_row(0, 1, 1'b1, 1'b0));
    // Largest x radius, a large y radius, coefficients at both ends of their range
    directed_rows.push_back(cfg_row(eop_pkg::REG_RX, 32'h0FFF_FFFF));
    directed_rows.push_back(cfg_row(eop_pkg::REG_RY, 32'hFFF0_0001));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M00, 32'h8000_0000));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M01, 32'h7FFF_FFFF));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M02, 32'h8000_0000));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M10, 32'h7FFF_FFFF));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M11, 32'h8000_0000));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M12, 32'h7FFF_FFFF));
    directed_rows.push_back(pix_row(PIX_MAX, PIX_MIN, 1'b0, 1'b0));
    directed_rows.push_back(pix_row(PIX_MIN, PIX_MAX, 1'b0, 1'b0));
    directed_rows.push_back(pix_row(PIX_MIN, PIX_MIN, 1'b0, 1'b0));
    directed_rows.push_back(pix_row(PIX_MAX, PIX_MAX, 1'b0, 1'b0));
    directed_rows.push_back(pix_row(0, 0, 1'b0, 1'b0));
    // Identity again with radii 3 and 2: the vertices lie on the outline
    directed_rows.push_back(cfg_row(eop_pkg::REG_M00, eop_pkg::COEF_ONE));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M01, eop_pkg::COEF_ZERO));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M02, eop_pkg::COEF_ZERO));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M10, eop_pkg::COEF_ZERO));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M11, eop_pkg::COEF_ONE));
    directed_rows.push_back(cfg_row(eop_pkg::REG_M12, eop_pkg::COEF_ZERO));
    directed_rows.push_back(cfg_row(eop_pkg::REG_RX, 3 << eop_pkg::FRAC_BITS));
    directed_rows.push_back(cfg_row(eop_pkg::REG_RY, 2 << eop_pkg::FRAC_BITS));
    directed_rows.push_back(pix_row(3, 0, 1'b1, 1'b1));
    directed_rows.push_back(pix_row(-3, 0, 1'b1, 1'b1));
    directed_rows.push_back(pix_row(0, -2, 1'b1, 1'b1));
    directed_rows.push_back(pix_row(2, 1, 1'b0, 1'b0));
    directed_rows.push_back(pix_row(3, 1, 1'b0, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table; register writes only once the pipeline is empty
    send_idle = 1'b1;
    recv_idle = 1'b1;
    cfg_open  = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) begin
          drain_pipeline();
        end
        write_reg(row.idx, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
        end
        cfg_open = 1'b0;
        send_pixel(row.x, row.y, row.typed, row.hit);
      end
    end

    // Random settings; the second one also squeezes the result side
    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      n = $urandom_range(30, 70);
      random_phase(n, phases_run == 1);
      sent_random += n;
      phases_run++;
    end

    drain_pipeline();
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("%0d pixels tested over %0d random settings, %0d of them on the outline band",
             pixels_sent, phases_run, hits_seen);
    $display("%0d register writes, %0d words checked, %0d mismatches",
             reg_writes, words_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
